// ----- rtl/core/lfsa_pkg.sv -----
// Package for the lowest-free slot allocator: slot count, field widths,
// request kinds and status codes. No dependencies.

package lfsa_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam kind_t KIND_CLAIM   = kind_t'(0);
  localparam kind_t KIND_RELEASE = kind_t'(1);
  localparam kind_t KIND_PROBE   = kind_t'(2);

  localparam status_t ST_OK           = status_t'(0);
  localparam status_t ST_FULL         = status_t'(1);
  localparam status_t ST_NEVER        = status_t'(2);
  localparam status_t ST_ALREADY_FREE = status_t'(3);

endpackage

// ----- rtl/core/lfsa_if.sv -----
// Valid/ready channel interfaces for the slot allocator: request and result.
// Depends on lfsa_pkg for field widths.

interface lfsa_req_if;
  logic               valid;
  logic               ready;
  lfsa_pkg::kind_t    kind;
  lfsa_pkg::slot_t    slot;
  lfsa_pkg::cnt_t     limit;

  modport source (output valid, kind, slot, limit, input ready);
  modport sink   (input valid, kind, slot, limit, output ready);
endinterface

interface lfsa_rsp_if;
  logic               valid;
  logic               ready;
  lfsa_pkg::slot_t    granted_slot;
  logic               fresh;
  lfsa_pkg::status_t  status;
  logic               below_ok;
  lfsa_pkg::cnt_t     active_count;
  lfsa_pkg::cnt_t     created_count;

  modport source (output valid, granted_slot, fresh, status, below_ok, active_count,
                  created_count, input ready);
  modport sink   (input valid, granted_slot, fresh, status, below_ok, active_count,
                  created_count, output ready);
endinterface

// ----- rtl/core/lowest_free_slot_allocator.sv -----
// Lowest-free slot allocator: claim, release and probe over a flop in-use map.
// Each request beat passes through the request register and then the result register,
// where its result is held valid until it is taken.
// Throughput: one request per cycle while the result side is ready; the lowest-free search
// is a single priority encode over the in-use map, done between the two registers.
// Reset (rst_n low, synchronous): in-use map and both counters cleared, no result held.
// Depends on lfsa_pkg and the channel interfaces in lfsa_if.sv.

module lowest_free_slot_allocator (
  input  logic           clk,
  input  logic           rst_n,
  lfsa_req_if.sink       in_req,
  lfsa_rsp_if.source     out_rsp
);

  // request register
  logic                  req_valid_r;
  lfsa_pkg::kind_t       req_kind_r;
  lfsa_pkg::slot_t       req_slot_r;
  lfsa_pkg::cnt_t        req_limit_r;

  // allocator state
  logic [lfsa_pkg::SLOTS-1:0] in_use_r, in_use_nxt;
  lfsa_pkg::cnt_t        active_r, active_nxt;
  lfsa_pkg::cnt_t        created_r, created_nxt;

  // result register
  logic                  rsp_valid_r;
  lfsa_pkg::slot_t       rsp_granted_r, granted_nxt;
  logic                  rsp_fresh_r, fresh_nxt;
  lfsa_pkg::status_t     rsp_status_r, status_nxt;
  logic                  rsp_below_r, below_nxt;

  logic                  rsp_free;
  logic                  do_step;

  logic [lfsa_pkg::SLOTS-1:0] created_mask;
  logic [lfsa_pkg::SLOTS-1:0] free_mask;
  logic [lfsa_pkg::SLOTS-1:0] lowest_oh;
  logic                  any_free;
  lfsa_pkg::slot_t       lowest_idx;
  lfsa_pkg::cnt_t        limit_sat;

  assign rsp_free     = !rsp_valid_r || out_rsp.ready;
  assign do_step      = req_valid_r && rsp_free;
  assign in_req.ready = !req_valid_r || do_step;

  // lowest free slot: isolate the lowest set bit, then fold it to an index
  always_comb begin
    for (int j = 0; j < lfsa_pkg::SLOTS; j++) begin
      created_mask[j] = (lfsa_pkg::cnt_t'(j) < created_r);
    end
    free_mask = ~in_use_r & created_mask;
    any_free  = |free_mask;
    lowest_oh = free_mask & (~free_mask + {{(lfsa_pkg::SLOTS-1){1'b0}}, 1'b1});
    lowest_idx = '0;
    for (int j = 0; j < lfsa_pkg::SLOTS; j++) begin
      if (lowest_oh[j]) begin
        lowest_idx = lowest_idx | lfsa_pkg::slot_t'(j);
      end
    end
  end

  assign limit_sat = (req_limit_r > lfsa_pkg::cnt_t'(lfsa_pkg::SLOTS)) ?
                     lfsa_pkg::cnt_t'(lfsa_pkg::SLOTS) : req_limit_r;

  always_comb begin
    in_use_nxt  = in_use_r;
    active_nxt  = active_r;
    created_nxt = created_r;
    granted_nxt = '0;
    fresh_nxt   = 1'b0;
    status_nxt  = lfsa_pkg::ST_OK;
    below_nxt   = 1'b0;
    unique case (req_kind_r)
      lfsa_pkg::KIND_CLAIM: begin
        if (any_free) begin
          in_use_nxt[lowest_idx] = 1'b1;
          active_nxt  = active_r + lfsa_pkg::cnt_t'(1);
          granted_nxt = lowest_idx;
        end else if (created_r < lfsa_pkg::cnt_t'(lfsa_pkg::SLOTS)) begin
          // grow the high-water mark by one fresh slot
          in_use_nxt[created_r[lfsa_pkg::SLOT_W-1:0]] = 1'b1;
          active_nxt  = active_r + lfsa_pkg::cnt_t'(1);
          created_nxt = created_r + lfsa_pkg::cnt_t'(1);
          granted_nxt = created_r[lfsa_pkg::SLOT_W-1:0];
          fresh_nxt   = 1'b1;
        end else begin
          status_nxt = lfsa_pkg::ST_FULL;
        end
      end
      lfsa_pkg::KIND_RELEASE: begin
        if (lfsa_pkg::cnt_t'(req_slot_r) >= created_r) begin
          status_nxt = lfsa_pkg::ST_NEVER;
        end else if (in_use_r[req_slot_r]) begin
          in_use_nxt[req_slot_r] = 1'b0;
          active_nxt = active_r - lfsa_pkg::cnt_t'(1);
        end else begin
          status_nxt = lfsa_pkg::ST_ALREADY_FREE;
        end
      end
      lfsa_pkg::KIND_PROBE: begin
        below_nxt = (limit_sat != '0) &&
                    ((created_r < limit_sat) ||
                     (any_free && (lfsa_pkg::cnt_t'(lowest_idx) < limit_sat)));
      end
      default: begin
        // unused kind: drop, report the counts only
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      rsp_valid_r <= 1'b0;
      in_use_r    <= '0;
      active_r    <= '0;
      created_r   <= '0;
    end else begin
      if (in_req.ready) begin
        req_valid_r <= in_req.valid;
      end
      if (do_step) begin
        in_use_r  <= in_use_nxt;
        active_r  <= active_nxt;
        created_r <= created_nxt;
      end
      if (rsp_free) begin
        rsp_valid_r <= req_valid_r;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_kind_r  <= in_req.kind;
      req_slot_r  <= in_req.slot;
      req_limit_r <= in_req.limit;
    end
    if (do_step) begin
      rsp_granted_r <= granted_nxt;
      rsp_fresh_r   <= fresh_nxt;
      rsp_status_r  <= status_nxt;
      rsp_below_r   <= below_nxt;
    end
  end

  // counts travel with the beat: state updates together with the result register
  assign out_rsp.valid         = rsp_valid_r;
  assign out_rsp.granted_slot  = rsp_granted_r;
  assign out_rsp.fresh         = rsp_fresh_r;
  assign out_rsp.status        = rsp_status_r;
  assign out_rsp.below_ok      = rsp_below_r;
  assign out_rsp.active_count  = active_r;
  assign out_rsp.created_count = created_r;

  a_active_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_use_r) == int'(active_r))
    else $error("active count disagrees with in-use map");

  a_active_le_created: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= created_r)
    else $error("more slots active than created");

  a_created_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> created_r >= $past(created_r))
    else $error("created count went down");

  a_fresh_is_top: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_valid_r && rsp_fresh_r) |->
      (rsp_status_r == lfsa_pkg::ST_OK &&
       lfsa_pkg::cnt_t'(rsp_granted_r) + lfsa_pkg::cnt_t'(1) == created_r))
    else $error("fresh grant is not the newest slot");

endmodule

// ----- sim/tb_lowest_free_slot_allocator.sv -----
// Testbench for lowest_free_slot_allocator: directed and random claim, release and
// probe beats, each result checked against an in-bench copy of the slot map.
// Depends on lfsa_pkg and the channel interfaces in lfsa_if.sv.

module tb_lowest_free_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam lfsa_pkg::kind_t KIND_UNUSED = lfsa_pkg::kind_t'(3);
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    lfsa_pkg::slot_t   granted_slot;
    logic              fresh;
    lfsa_pkg::status_t status;
    logic              below_ok;
    lfsa_pkg::cnt_t    active_count;
    lfsa_pkg::cnt_t    created_count;
  } slot_answer_t;

  logic clk;
  logic rst_n;

  lfsa_req_if req_if();
  lfsa_rsp_if rsp_if();

  lowest_free_slot_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  // Slot map as the block should hold it
  logic [lfsa_pkg::SLOTS-1:0] slot_busy;
  int               claimed_total;
  int               made_total;

  slot_answer_t slot_answers[$];
  int           mismatch_count;
  int           gap_pct;
  int           stall_pct;
  int           stall_hold;
  int unsigned  cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic int first_free_slot();
    int lo;
    lo = -1;
    for (int j = lfsa_pkg::SLOTS - 1; j >= 0; j--) begin
      if (j < made_total && !slot_busy[j]) lo = j;
    end
    return lo;
  endfunction

  function automatic slot_answer_t step_slot_map(lfsa_pkg::kind_t k, lfsa_pkg::slot_t s,
                                                 lfsa_pkg::cnt_t lim);
    slot_answer_t ans;
    int lo;
    int bound;
    ans = '0;
    lo = first_free_slot();
    case (k)
      lfsa_pkg::KIND_CLAIM: begin
        if (lo >= 0) begin
          slot_busy[lo] = 1'b1;
          claimed_total++;
          ans.granted_slot = lfsa_pkg::slot_t'(lo);
        end else if (made_total < lfsa_pkg::SLOTS) begin
          slot_busy[made_total] = 1'b1;
          ans.granted_slot = lfsa_pkg::slot_t'(made_total);
          ans.fresh = 1'b1;
          made_total++;
          claimed_total++;
        end else begin
          ans.status = lfsa_pkg::ST_FULL;
        end
      end
      lfsa_pkg::KIND_RELEASE: begin
        if (int'(s) >= made_total) begin
          ans.status = lfsa_pkg::ST_NEVER;
        end else if (slot_busy[s]) begin
          slot_busy[s] = 1'b0;
          claimed_total--;
        end else begin
          ans.status = lfsa_pkg::ST_ALREADY_FREE;
        end
      end
      lfsa_pkg::KIND_PROBE: begin
        bound = (int'(lim) > lfsa_pkg::SLOTS) ? lfsa_pkg::SLOTS : int'(lim);
        ans.below_ok = (bound != 0) && (made_total < bound || (lo >= 0 && lo < bound));
      end
      default: ;
    endcase
    ans.active_count  = lfsa_pkg::cnt_t'(claimed_total);
    ans.created_count = lfsa_pkg::cnt_t'(made_total);
    return ans;
  endfunction

  task automatic issue_request(lfsa_pkg::kind_t k, lfsa_pkg::slot_t s, lfsa_pkg::cnt_t lim);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= k;
    req_if.slot  <= s;
    req_if.limit <= lim;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    slot_answers.push_back(step_slot_map(k, s, lim));
  endtask

  // Drop valid, then hold until every expected result has been taken
  task automatic wait_all_answered();
    req_if.valid <= 1'b0;
    while (slot_answers.size() != 0) @(posedge clk);
  endtask

  task automatic check_answer();
    slot_answer_t want;
    if (slot_answers.size() == 0) begin
      $error("result beat with no request outstanding");
      mismatch_count++;
    end else begin
      want = slot_answers.pop_front();
      if (rsp_if.granted_slot !== want.granted_slot) begin
        $error("granted_slot: expected %0d, got %0d", want.granted_slot, rsp_if.granted_slot);
        mismatch_count++;
      end
      if (rsp_if.fresh !== want.fresh) begin
        $error("fresh: expected %0d, got %0d", want.fresh, rsp_if.fresh);
        mismatch_count++;
      end
      if (rsp_if.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
        mismatch_count++;
      end
      if (rsp_if.below_ok !== want.below_ok) begin
        $error("below_ok: expected %0d, got %0d", want.below_ok, rsp_if.below_ok);
        mismatch_count++;
      end
      if (rsp_if.active_count !== want.active_count) begin
        $error("active_count: expected %0d, got %0d", want.active_count, rsp_if.active_count);
        mismatch_count++;
      end
      if (rsp_if.created_count !== want.created_count) begin
        $error("created_count: expected %0d, got %0d", want.created_count,
               rsp_if.created_count);
        mismatch_count++;
      end
    end
  endtask

  // Result side: check the beat taken at this edge, then choose ready for the next
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) check_answer();
      if (stall_hold > 0) begin
        rsp_if.ready <= 1'b0;
        stall_hold--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // One random beat; claim_pct biases the map towards filling or emptying
  task automatic random_request(int claim_pct);
    int              pick;
    int              lo;
    lfsa_pkg::slot_t s;
    lfsa_pkg::cnt_t  lim;
    pick = $urandom_range(99);
    s    = lfsa_pkg::slot_t'($urandom_range(lfsa_pkg::SLOTS - 1));
    lim  = lfsa_pkg::cnt_t'($urandom_range(127));
    if (pick < 3) begin
      issue_request(KIND_UNUSED, s, lim);
    end else if (pick < 3 + claim_pct) begin
      issue_request(lfsa_pkg::KIND_CLAIM, s, lim);
    end else if (pick < 85) begin
      if (made_total > 0 && $urandom_range(99) < 75) begin
        s = lfsa_pkg::slot_t'($urandom_range(made_total - 1));
      end
      issue_request(lfsa_pkg::KIND_RELEASE, s, lim);
    end else begin
      // aim at the edge around the lowest free slot or the high-water mark
      lo = first_free_slot();
      case ($urandom_range(3))
        0: if (lo >= 0) lim = lfsa_pkg::cnt_t'(lo + $urandom_range(1));
        1: lim = lfsa_pkg::cnt_t'(made_total + $urandom_range(1));
        2: lim = lfsa_pkg::cnt_t'($urandom_range(lfsa_pkg::SLOTS));
        default: ;
      endcase
      issue_request(lfsa_pkg::KIND_PROBE, s, lim);
    end
  endtask

  task automatic test_basic_ops();
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(0));
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(1));
    issue_request(lfsa_pkg::KIND_RELEASE, lfsa_pkg::slot_t'(0), '0);
    issue_request(KIND_UNUSED, '1, '1);
    issue_request(lfsa_pkg::KIND_CLAIM, '1, '1);
    issue_request(lfsa_pkg::KIND_CLAIM, '0, '0);
    issue_request(lfsa_pkg::KIND_CLAIM, '0, '0);
    issue_request(lfsa_pkg::KIND_RELEASE, lfsa_pkg::slot_t'(1), '0);
    issue_request(lfsa_pkg::KIND_RELEASE, lfsa_pkg::slot_t'(1), '0);
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(1));
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(2));
    issue_request(lfsa_pkg::KIND_CLAIM, '0, '0);
    issue_request(lfsa_pkg::KIND_RELEASE, lfsa_pkg::slot_t'(63), '0);
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(127));
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(64));
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(65));
    issue_request(lfsa_pkg::KIND_RELEASE, lfsa_pkg::slot_t'(0), '0);
    issue_request(lfsa_pkg::KIND_RELEASE, lfsa_pkg::slot_t'(2), '0);
    issue_request(lfsa_pkg::KIND_CLAIM, '0, '0);
    issue_request(lfsa_pkg::KIND_CLAIM, '0, '0);
    wait_all_answered();
  endtask

  task automatic test_full_map();
    while (made_total < lfsa_pkg::SLOTS || claimed_total < lfsa_pkg::SLOTS) begin
      issue_request(lfsa_pkg::KIND_CLAIM, '0, '0);
    end
    issue_request(lfsa_pkg::KIND_CLAIM, '0, '0);
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(64));
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(127));
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(0));
    issue_request(lfsa_pkg::KIND_RELEASE, lfsa_pkg::slot_t'(63), '0);
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(63));
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(64));
    issue_request(lfsa_pkg::KIND_CLAIM, '0, '0);
    issue_request(lfsa_pkg::KIND_RELEASE, lfsa_pkg::slot_t'(0), '0);
    issue_request(lfsa_pkg::KIND_PROBE, '0, lfsa_pkg::cnt_t'(1));
    issue_request(KIND_UNUSED, '0, '0);
    wait_all_answered();
  endtask

  // Hold the result side off long enough for the block to back up into its input
  task automatic test_backpressure();
    gap_pct    = 0;
    stall_pct  = 0;
    stall_hold = 150;
    repeat (40) random_request(50);
    wait_all_answered();
  endtask

  task automatic run_random_mix(int items, int gap, int stall);
    int left;
    int seg;
    int claim_pct;
    gap_pct   = gap;
    stall_pct = stall;
    left      = items;
    while (left > 0) begin
      seg = $urandom_range(30, 90);
      case ($urandom_range(2))
        0: claim_pct = 80;
        1: claim_pct = 45;
        default: claim_pct = 15;
      endcase
      while (seg > 0 && left > 0) begin
        random_request(claim_pct);
        seg--;
        left--;
      end
    end
    wait_all_answered();
  endtask

  initial begin
    slot_busy      = '0;
    claimed_total  = 0;
    made_total     = 0;
    mismatch_count = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    stall_hold     = 0;
    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.kind  <= lfsa_pkg::KIND_CLAIM;
    req_if.slot  <= '0;
    req_if.limit <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_full_map();
    test_backpressure();
    run_random_mix(175, 0, 0);
    run_random_mix(175, 73, 0);
    run_random_mix(175, 0, 73);
    run_random_mix(185, 32, 32);

    gap_pct   = 0;
    stall_pct = 0;
    wait_all_answered();
    // catch any stray beat after the last expected one
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
